>>> src/fnpll_pkg.sv
// ----------------------------------------------------------------------------
// Fractional-N PLL setting calculator package
// Shared widths, register indexes, operation codes and control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package fnpll_pkg;

  localparam int TARGET_W   = 33;
  localparam int SPACING_W  = 27;
  localparam int REF_W      = 28;
  localparam int RDIV_W     = 10;
  localparam int VMIN_MHZ_W = 16;
  localparam int INT_W      = 16;
  localparam int FRAC_W     = 12;
  localparam int CODE_W     = 3;

  localparam int PNUM_W     = REF_W + 1;          // reference, possibly doubled
  localparam int PDEN_W     = RDIV_W + 1;         // R divider, possibly doubled
  localparam int VMIN_W     = 36;                 // 65535 * 1e6 fits in 36 bits
  localparam int STEP_W     = PDEN_W + SPACING_W; // pden * spacing
  localparam int DSR_W      = STEP_W + 1;         // widest divisor: 2 * step
  localparam int FM_W       = PNUM_W + 1;         // unmasked FRAC and MOD

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = REF_W;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;

  localparam int DEF_MAX_OUT_DIV_LOG2 = 4;

  localparam logic [19:0] HZ_PER_MHZ = 20'd1000000;

  localparam logic [CFG_IDX_W-1:0] REG_REF_HZ      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_DOUBLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF_HALF    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REF_DIVIDER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VCO_MIN_MHZ = 3'd4;

  localparam logic [1:0] OP_N    = 2'd0;
  localparam logic [1:0] OP_FRAC = 2'd1;
  localparam logic [1:0] OP_MOD  = 2'd2;

  typedef struct packed {
    logic       load;
    logic       sel_step;
    logic       mul;
    logic       div_start;
    logic       red_step;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sel_done;
    logic pfd_zero;
    logic spc_zero;
    logic div_done;
    logic red_done;
    logic out_busy;
  } ctrl_stat_t;

endpackage

`default_nettype wire

>>> src/fnpll_div.sv
// ----------------------------------------------------------------------------
// Fractional-N PLL iterative divider
// Restoring divider, one quotient bit per cycle, registered results.
// ----------------------------------------------------------------------------
`default_nettype none

module fnpll_div #(
  parameter int DVD_W = 48,
  parameter int DSR_W = 39
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DSR_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient,
  output logic [DSR_W-1:0]      remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] dvd;
  logic [DSR_W-1:0] dsr;
  logic [DSR_W-1:0] rmd;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             ge;

  assign trial = {rmd, dvd[DVD_W-1]};
  assign ge    = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(DVD_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend register fills with quotient bits from the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rmd <= '0;
    end else if (cnt != '0) begin
      dvd <= {dvd[DVD_W-2:0], ge};
      rmd <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
    end
  end

  assign quotient  = dvd;
  assign remainder = rmd;

endmodule

`default_nettype wire

>>> src/fnpll_dp.sv
// ----------------------------------------------------------------------------
// Fractional-N PLL datapath
// Configuration registers, operand registers, divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fnpll_dp #(
  parameter int MAX_OUT_DIV_LOG2 = fnpll_pkg::DEF_MAX_OUT_DIV_LOG2
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  input  wire logic [fnpll_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fnpll_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [fnpll_pkg::IN_DATA_W-1:0] in_data,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic [fnpll_pkg::OUT_DATA_W-1:0]     out_data,
  input  wire fnpll_pkg::ctrl_cmd_t            cmd,
  output fnpll_pkg::ctrl_stat_t                stat
);
  import fnpll_pkg::*;

  localparam int VCO_W = TARGET_W + MAX_OUT_DIV_LOG2;
  localparam int DVD_W = VCO_W + PDEN_W;

  logic [REF_W-1:0]      ref_hz;
  logic                  ref_double;
  logic                  ref_half;
  logic [RDIV_W-1:0]     ref_divider;
  logic [VMIN_MHZ_W-1:0] vco_min_mhz;

  logic [SPACING_W-1:0]  spacing;
  logic [VMIN_W-1:0]     vmin;
  logic [VCO_W-1:0]      vco;
  logic [CODE_W-1:0]     code;
  logic [PNUM_W-1:0]     pnum;
  logic [PDEN_W-1:0]     pden;
  logic [DVD_W-1:0]      scaled;
  logic [STEP_W-1:0]     step;
  logic [INT_W-1:0]      n;
  logic [PNUM_W-1:0]     rem;
  logic [FM_W-1:0]       frac;
  logic [FM_W-1:0]       modv;
  logic [1:0]            op;

  logic [PDEN_W-1:0]     pden_next;
  logic [RDIV_W-1:0]     rdiv_eff;
  logic [DVD_W-1:0]      div_dvd;
  logic [DSR_W-1:0]      div_dsr;
  logic                  div_done;
  logic [DVD_W-1:0]      div_quo;
  logic [DSR_W-1:0]      div_rmd;
  logic                  fm_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_hz      <= REF_W'(10000000);
      ref_double  <= 1'b0;
      ref_half    <= 1'b0;
      ref_divider <= RDIV_W'(1);
      vco_min_mhz <= VMIN_MHZ_W'(2200);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_REF_HZ:      ref_hz      <= cfg_data;
        REG_REF_DOUBLE:  ref_double  <= cfg_data[0];
        REG_REF_HALF:    ref_half    <= cfg_data[0];
        REG_REF_DIVIDER: ref_divider <= cfg_data[RDIV_W-1:0];
        REG_VCO_MIN_MHZ: vco_min_mhz <= cfg_data[VMIN_MHZ_W-1:0];
        default: ;
      endcase
    end
  end

  assign rdiv_eff  = (ref_divider > RDIV_W'(1)) ? ref_divider : RDIV_W'(1);
  assign pden_next = ref_half ? {rdiv_eff, 1'b0} : {1'b0, rdiv_eff};

  always_comb begin
    case (op)
      OP_N: begin
        div_dvd = scaled;
        div_dsr = DSR_W'(pnum);
      end
      OP_FRAC: begin
        div_dvd = DVD_W'({rem, 1'b0}) + DVD_W'(step);
        div_dsr = {step, 1'b0};
      end
      default: begin
        div_dvd = DVD_W'({pnum, 1'b0}) + DVD_W'(step);
        div_dsr = {step, 1'b0};
      end
    endcase
  end

  fnpll_div #(
    .DVD_W(DVD_W),
    .DSR_W(DSR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rmd)
  );

  assign fm_zero = (frac == '0) || (modv == '0);

  // The operand mux follows op, so op is updated before the divider start is given.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      spacing <= in_data[TARGET_W +: SPACING_W];
      vco     <= VCO_W'(in_data[TARGET_W-1:0]);
      vmin    <= VMIN_W'(vco_min_mhz) * VMIN_W'(HZ_PER_MHZ);
      pnum    <= ref_double ? {ref_hz, 1'b0} : {1'b0, ref_hz};
      pden    <= pden_next;
      code    <= '0;
      n       <= '0;
      rem     <= '0;
      frac    <= '0;
      modv    <= '0;
    end else begin
      if (cmd.sel_step) begin
        vco  <= {vco[VCO_W-2:0], 1'b0};
        code <= code + 1'b1;
      end
      if (cmd.mul) begin
        scaled <= DVD_W'(vco) * DVD_W'(pden);
        step   <= STEP_W'(pden) * STEP_W'(spacing);
      end
      if (div_done) begin
        case (op)
          OP_N: begin
            n   <= div_quo[INT_W-1:0];
            rem <= div_rmd[PNUM_W-1:0];
          end
          OP_FRAC: frac <= div_quo[FM_W-1:0];
          default: modv <= div_quo[FM_W-1:0];
        endcase
      end
      if (cmd.red_step) begin
        if (fm_zero) begin
          frac <= '0;
          modv <= FM_W'(1);
        end else if (!frac[0] && !modv[0]) begin
          frac <= {1'b0, frac[FM_W-1:1]};
          modv <= {1'b0, modv[FM_W-1:1]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op <= OP_N;
    end else if (cmd.sel_step || cmd.mul || cmd.red_step || cmd.load) begin
      op <= OP_N;
    end else if (div_done) begin
      op <= (op == OP_N) ? OP_FRAC : OP_MOD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {5'd0, code, modv[FRAC_W-1:0], frac[FRAC_W-1:0], n};
    end
  end

  assign stat.sel_done = (code == CODE_W'(MAX_OUT_DIV_LOG2)) ||
                         (DVD_W'(vco) > DVD_W'(vmin));
  assign stat.pfd_zero = (pnum == '0);
  assign stat.spc_zero = (spacing == '0);
  assign stat.div_done = div_done;
  assign stat.red_done = fm_zero || frac[0] || modv[0];
  assign stat.out_busy = out_valid && !out_ready;

endmodule

`default_nettype wire

>>> src/fnpll_ctrl.sv
// ----------------------------------------------------------------------------
// Fractional-N PLL controller
// Sequences divider selection, the multiply, up to three divisions, the reduction and the output load.
// ----------------------------------------------------------------------------
`default_nettype none

module fnpll_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire fnpll_pkg::ctrl_stat_t stat,
  output fnpll_pkg::ctrl_cmd_t       cmd,
  output logic                       busy
);
  import fnpll_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SEL    = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_N_GO   = 4'd3;
  localparam logic [3:0] S_N_WAIT = 4'd4;
  localparam logic [3:0] S_F_GO   = 4'd5;
  localparam logic [3:0] S_F_WAIT = 4'd6;
  localparam logic [3:0] S_M_GO   = 4'd7;
  localparam logic [3:0] S_M_WAIT = 4'd8;
  localparam logic [3:0] S_RED    = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SEL;
        end
      end
      S_SEL: begin
        if (stat.sel_done) begin
          state_next = S_MUL;
        end else begin
          cmd.sel_step = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = stat.pfd_zero ? S_RED : S_N_GO;
      end
      S_N_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_N_WAIT;
      end
      S_N_WAIT: begin
        if (stat.div_done) begin
          state_next = stat.spc_zero ? S_RED : S_F_GO;
        end
      end
      S_F_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_F_WAIT;
      end
      S_F_WAIT: begin
        if (stat.div_done) begin
          state_next = S_M_GO;
        end
      end
      S_M_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_M_WAIT;
      end
      S_M_WAIT: begin
        if (stat.div_done) begin
          state_next = S_RED;
        end
      end
      S_RED: begin
        cmd.red_step = 1'b1;
        if (stat.red_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

>>> src/frac_n_pll_setting_calc_top.sv
// Sequence: accept, output-divider selection, a multiply, up to three divisions through one
// shared bit-serial divider, reduction of FRAC and MOD, and the output load.
// Throughput: one request at a time; the next request is taken once the result sits
// in the output register. Reset (rst, synchronous) restores the register defaults and
// empties the controller and the output register.
// ----------------------------------------------------------------------------
// Fractional-N PLL setting calculator
// Computes N, FRAC, MOD and the output divider code from a target frequency.
// ----------------------------------------------------------------------------
`default_nettype none

module frac_n_pll_setting_calc_top #(
  parameter int MAX_OUT_DIV_LOG2 = fnpll_pkg::DEF_MAX_OUT_DIV_LOG2
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [fnpll_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fnpll_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // target_hz [32:0], spacing_hz [59:33]
  input  wire logic [fnpll_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // int_count [15:0], frac_num [27:16], frac_mod [39:28], div_code [42:40]
  output logic [fnpll_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
  import fnpll_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  logic       busy;

  assign cfg_ready = 1'b1;

  fnpll_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  fnpll_dp #(
    .MAX_OUT_DIV_LOG2(MAX_OUT_DIV_LOG2)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (s_axis_tdata),
    .out_ready(m_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_data (m_axis_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (busy && !s_axis_tready))
    else $error("controller not busy after accepting a request");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[42:40] <= CODE_W'(MAX_OUT_DIV_LOG2)))
    else $error("divider code beyond its limit");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten before it was taken");
`endif

endmodule

`default_nettype wire
